### rtl/smpg_pkg.sv
`default_nettype none
package smpg_pkg;

	localparam int MAX_DIVISIONS_DEF = 1023;
	localparam int TRIG_BITS_DEF     = 16;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int CNT_W      = 10;
	localparam int RAD_W      = 16;
	localparam int CORNER_W   = 20;

	localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RINGS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SECTS  = 2'd2;

	localparam logic [RAD_W-1:0] RADIUS_RST = 16'd154;
	localparam logic [CNT_W-1:0] COUNT_RST  = 10'd100;

	localparam int CORDIC_STEPS = 28;
	localparam logic signed [32:0] CORDIC_X0 = 33'sd652032874;

	localparam logic [31:0] ATAN_TURN [CORDIC_STEPS] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
		32'h00000014, 32'h0000000A, 32'h00000005
	};

endpackage
`default_nettype wire

### rtl/smpg_in_if.sv
`default_nettype none
interface smpg_in_if;
	logic                          valid;
	logic                          ready;
	logic [smpg_pkg::CNT_W-1:0]    ring_index;
	logic [smpg_pkg::CNT_W-1:0]    sector_index;

	modport source (output valid, output ring_index, output sector_index, input ready);
	modport sink   (input valid, input ring_index, input sector_index, output ready);
endinterface
`default_nettype wire

### rtl/smpg_out_if.sv
`default_nettype none
interface smpg_out_if;
	logic                            valid;
	logic                            ready;
	logic signed [16:0]              pos_x;
	logic signed [16:0]              pos_y;
	logic signed [16:0]              pos_z;
	logic signed [15:0]              norm_x;
	logic signed [15:0]              norm_y;
	logic signed [15:0]              norm_z;
	logic                            quad_valid;
	logic [smpg_pkg::CORNER_W-1:0]   corner_a;
	logic [smpg_pkg::CORNER_W-1:0]   corner_b;
	logic [smpg_pkg::CORNER_W-1:0]   corner_c;
	logic [smpg_pkg::CORNER_W-1:0]   corner_d;

	modport source (output valid, output pos_x, output pos_y, output pos_z,
		output norm_x, output norm_y, output norm_z, output quad_valid,
		output corner_a, output corner_b, output corner_c, output corner_d,
		input ready);
	modport sink   (input valid, input pos_x, input pos_y, input pos_z,
		input norm_x, input norm_y, input norm_z, input quad_valid,
		input corner_a, input corner_b, input corner_c, input corner_d,
		output ready);
endinterface
`default_nettype wire

### rtl/sphere_mesh_point_generator.sv
`default_nettype none
// channel  | direction | payload
// in_ch    | sink      | ring_index, sector_index
// out_ch   | source    | pos_x/y/z, norm_x/y/z, quad_valid, corner_a..d
// cfg      | write     | cfg_we, cfg_idx, cfg_data (radius, ring_count, sector_count)
//
// one transaction per cycle sustained while out_ch.ready stays high
// pipeline: one entry stage, TRIG_BITS + 1 divider stages, 28 cordic stages, five output stages
// the latency is set by the one-bit-per-stage divider and the one-step-per-stage cordic
// reset loads the register defaults and clears all valid bits
// a stalled output holds the whole pipeline; a one-entry input skid takes one more item
module sphere_mesh_point_generator #(
	parameter int MAX_DIVISIONS = smpg_pkg::MAX_DIVISIONS_DEF,
	parameter int TRIG_BITS     = smpg_pkg::TRIG_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	smpg_in_if.sink                                in_ch,
	smpg_out_if.source                             out_ch,
	input  wire logic                              cfg_we,
	input  wire logic [smpg_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  wire logic [smpg_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int QW = TRIG_BITS + 1;
	localparam int NW = QW + smpg_pkg::CNT_W;
	localparam int CW = smpg_pkg::CNT_W;
	localparam int KW = smpg_pkg::CORNER_W;
	localparam int CS = smpg_pkg::CORDIC_STEPS;
	localparam logic [CW-1:0] MAXD = CW'(MAX_DIVISIONS);

	typedef struct packed {
		logic [CW-1:0] rem;
		logic [QW-1:0] num;
		logic [QW-1:0] q;
	} div_t;

	typedef struct packed {
		logic          qv;
		logic [KW-1:0] a;
		logic [KW-1:0] b;
		logic [KW-1:0] c;
		logic [KW-1:0] d;
	} side_t;

	typedef struct packed {
		logic signed [32:0] x;
		logic signed [32:0] y;
		logic signed [32:0] z;
	} cord_t;

	function automatic logic [CW-1:0] clamp_cnt(input logic [CW-1:0] n);
		logic [CW-1:0] r;
		if (n == '0) r = CW'(1);
		else if (32'(n) > MAX_DIVISIONS) r = MAXD;
		else r = n;
		return r;
	endfunction

	function automatic div_t div_step(input div_t s, input logic [CW-1:0] dv);
		logic [CW:0] t;
		logic [CW:0] df;
		logic        ge;
		div_t        o;
		t  = {s.rem, s.num[QW-1]};
		ge = t >= {1'b0, dv};
		df = t - {1'b0, dv};
		o.rem = ge ? df[CW-1:0] : t[CW-1:0];
		o.num = {s.num[QW-2:0], 1'b0};
		o.q   = {s.q[QW-2:0], ge};
		return o;
	endfunction

	function automatic cord_t cord_init(input logic [QW-1:0] q);
		logic [31:0] ang;
		cord_t       o;
		ang = 32'(q[TRIG_BITS-1:0]) << (32 - TRIG_BITS);
		o.x = smpg_pkg::CORDIC_X0;
		o.y = '0;
		o.z = $signed({3'b000, ang[29:0]});
		return o;
	endfunction

	function automatic logic [1:0] quad_of(input logic [QW-1:0] q);
		logic [31:0] ang;
		ang = 32'(q[TRIG_BITS-1:0]) << (32 - TRIG_BITS);
		return ang[31:30];
	endfunction

	function automatic cord_t cord_step(input cord_t s, input int k);
		logic signed [32:0] xs;
		logic signed [32:0] ys;
		logic signed [32:0] dx;
		logic signed [32:0] dy;
		logic signed [32:0] at;
		cord_t              o;
		xs = s.x;
		ys = s.y;
		dx = ys >>> k;
		dy = xs >>> k;
		at = $signed({1'b0, smpg_pkg::ATAN_TURN[k]});
		if (!s.z[32]) begin
			o.x = xs - dx;
			o.y = ys + dy;
			o.z = s.z - at;
		end else begin
			o.x = xs + dx;
			o.y = ys - dy;
			o.z = s.z + at;
		end
		return o;
	endfunction

	function automatic logic signed [15:0] norm_prod(input logic signed [65:0] p);
		logic [65:0] mag;
		logic [65:0] r;
		logic [15:0] m;
		mag = p[65] ? 66'(-p) : 66'(p);
		r   = (mag + (66'd1 << 44)) >> 45;
		m   = (r > 66'd32767) ? 16'd32767 : r[15:0];
		return p[65] ? $signed(-m) : $signed(m);
	endfunction

	function automatic logic signed [15:0] norm_cos(input logic signed [32:0] c);
		logic [32:0] mag;
		logic [32:0] r;
		logic [15:0] m;
		mag = c[32] ? 33'(-c) : 33'(c);
		r   = (mag + (33'd1 << 14)) >> 15;
		m   = (r > 33'd32767) ? 16'd32767 : r[15:0];
		return c[32] ? $signed(m) : $signed(-m);
	endfunction

	function automatic logic signed [16:0] pos_round(input logic signed [32:0] p);
		logic [32:0] mag;
		logic [32:0] r;
		mag = p[32] ? 33'(-p) : 33'(p);
		r   = (mag + (33'd1 << 14)) >> 15;
		return p[32] ? $signed(-r[16:0]) : $signed(r[16:0]);
	endfunction

	// configuration
	logic [smpg_pkg::RAD_W-1:0] radius_q;
	logic [CW-1:0]              rings_q;
	logic [CW-1:0]              sects_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= smpg_pkg::RADIUS_RST;
			rings_q  <= smpg_pkg::COUNT_RST;
			sects_q  <= smpg_pkg::COUNT_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				smpg_pkg::REG_RADIUS: radius_q <= cfg_data[smpg_pkg::RAD_W-1:0];
				smpg_pkg::REG_RINGS:  rings_q  <= cfg_data[CW-1:0];
				smpg_pkg::REG_SECTS:  sects_q  <= cfg_data[CW-1:0];
				default: ;
			endcase
		end
	end

	logic [CW-1:0] rc;
	logic [CW-1:0] sc;
	assign rc = clamp_cnt(rings_q);
	assign sc = clamp_cnt(sects_q);

	// flow control and input skid
	logic          adv;
	logic          v_s8;
	logic          skid_v_q;
	logic [CW-1:0] skid_ri_q;
	logic [CW-1:0] skid_si_q;

	assign adv         = !v_s8 || out_ch.ready;
	assign in_ch.ready = !skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_v_q <= 1'b0;
		end else if (adv) begin
			skid_v_q <= 1'b0;
		end else if (in_ch.valid && !skid_v_q) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!adv && in_ch.valid && !skid_v_q) begin
			skid_ri_q <= in_ch.ring_index;
			skid_si_q <= in_ch.sector_index;
		end
	end

	// entry stage: clamp, corners, dividends
	logic          src_v;
	logic [CW-1:0] src_ri;
	logic [CW-1:0] src_si;
	logic [CW-1:0] ri_c;
	logic [CW-1:0] si_c;
	logic [20:0]   a_w;
	logic [KW-1:0] b_w;
	logic [NW-1:0] num_lon;
	logic [NW-1:0] num_lat;
	side_t         side_w;
	div_t          lon_w;
	div_t          lat_w;

	assign src_v  = skid_v_q || in_ch.valid;
	assign src_ri = skid_v_q ? skid_ri_q : in_ch.ring_index;
	assign src_si = skid_v_q ? skid_si_q : in_ch.sector_index;

	always_comb begin
		ri_c    = (src_ri > rc) ? rc : src_ri;
		si_c    = (src_si > sc) ? sc : src_si;
		a_w     = 21'(ri_c) * 21'({1'b0, sc} + 11'd1) + 21'(si_c);
		b_w     = a_w[KW-1:0] + KW'({1'b0, sc} + 11'd1);
		num_lon = (NW'(si_c) << TRIG_BITS) + NW'(sc >> 1);
		num_lat = (NW'(ri_c) << (TRIG_BITS - 1)) + NW'(rc >> 1);
		side_w.qv = (ri_c < rc) && (si_c < sc);
		side_w.a  = side_w.qv ? a_w[KW-1:0] : '0;
		side_w.b  = side_w.qv ? b_w : '0;
		side_w.c  = side_w.qv ? b_w + KW'(1) : '0;
		side_w.d  = side_w.qv ? a_w[KW-1:0] + KW'(1) : '0;
		lon_w.rem = num_lon[NW-1:QW];
		lon_w.num = num_lon[QW-1:0];
		lon_w.q   = '0;
		lat_w.rem = num_lat[NW-1:QW];
		lat_w.num = num_lat[QW-1:0];
		lat_w.q   = '0;
	end

	logic  v_s1;
	side_t side_s1;
	div_t  lon_s1;
	div_t  lat_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= src_v;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1 <= side_w;
			lon_s1  <= lon_w;
			lat_s1  <= lat_w;
		end
	end

	// divider stages, one quotient bit each
	logic  v_s2    [QW];
	side_t side_s2 [QW];
	div_t  lon_s2  [QW];
	div_t  lat_s2  [QW];

	for (genvar k = 0; k < QW; k++) begin : g_div
		logic  vi;
		side_t si;
		div_t  li;
		div_t  ai;
		if (k == 0) begin : g_first
			assign vi = v_s1;
			assign si = side_s1;
			assign li = lon_s1;
			assign ai = lat_s1;
		end else begin : g_next
			assign vi = v_s2[k-1];
			assign si = side_s2[k-1];
			assign li = lon_s2[k-1];
			assign ai = lat_s2[k-1];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s2[k] <= 1'b0;
			else if (adv) v_s2[k] <= vi;
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				side_s2[k] <= si;
				lon_s2[k]  <= div_step(li, sc);
				lat_s2[k]  <= div_step(ai, rc);
			end
		end
	end

	// cordic stages, one rotation each
	logic       v_s3     [CS];
	side_t      side_s3  [CS];
	logic [1:0] qlon_s3  [CS];
	logic [1:0] qlat_s3  [CS];
	cord_t      lon_s3   [CS];
	cord_t      lat_s3   [CS];

	for (genvar k = 0; k < CS; k++) begin : g_cord
		logic       vi;
		side_t      si;
		logic [1:0] qo;
		logic [1:0] qa;
		cord_t      li;
		cord_t      ai;
		if (k == 0) begin : g_first
			assign vi = v_s2[QW-1];
			assign si = side_s2[QW-1];
			assign qo = quad_of(lon_s2[QW-1].q);
			assign qa = quad_of(lat_s2[QW-1].q);
			assign li = cord_init(lon_s2[QW-1].q);
			assign ai = cord_init(lat_s2[QW-1].q);
		end else begin : g_next
			assign vi = v_s3[k-1];
			assign si = side_s3[k-1];
			assign qo = qlon_s3[k-1];
			assign qa = qlat_s3[k-1];
			assign li = lon_s3[k-1];
			assign ai = lat_s3[k-1];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s3[k] <= 1'b0;
			else if (adv) v_s3[k] <= vi;
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				side_s3[k] <= si;
				qlon_s3[k] <= qo;
				qlat_s3[k] <= qa;
				lon_s3[k]  <= cord_step(li, k);
				lat_s3[k]  <= cord_step(ai, k);
			end
		end
	end

	// quadrant fold
	logic               v_s4;
	side_t              side_s4;
	logic signed [32:0] cl_s4;
	logic signed [32:0] sl_s4;
	logic signed [32:0] ct_s4;
	logic signed [32:0] st_s4;
	logic signed [32:0] lx;
	logic signed [32:0] ly;
	logic signed [32:0] ax;
	logic signed [32:0] ay;
	logic signed [32:0] cl_w;
	logic signed [32:0] sl_w;
	logic signed [32:0] ct_w;
	logic signed [32:0] st_w;

	assign lx = lon_s3[CS-1].x;
	assign ly = lon_s3[CS-1].y;
	assign ax = lat_s3[CS-1].x;
	assign ay = lat_s3[CS-1].y;

	always_comb begin
		unique case (qlon_s3[CS-1])
			2'd0: begin cl_w = lx;  sl_w = ly;  end
			2'd1: begin cl_w = -ly; sl_w = lx;  end
			2'd2: begin cl_w = -lx; sl_w = -ly; end
			default: begin cl_w = ly; sl_w = -lx; end
		endcase
		unique case (qlat_s3[CS-1])
			2'd0: begin ct_w = ax;  st_w = ay;  end
			2'd1: begin ct_w = -ay; st_w = ax;  end
			2'd2: begin ct_w = -ax; st_w = -ay; end
			default: begin ct_w = ay; st_w = -ax; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (adv) v_s4 <= v_s3[CS-1];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s4 <= side_s3[CS-1];
			cl_s4   <= cl_w;
			sl_s4   <= sl_w;
			ct_s4   <= ct_w;
			st_s4   <= st_w;
		end
	end

	// products, normals, position products, positions
	logic               v_s5;
	side_t              side_s5;
	logic signed [65:0] px_s5;
	logic signed [65:0] pz_s5;
	logic signed [32:0] ct_s5;
	logic               v_s6;
	side_t              side_s6;
	logic signed [15:0] nx_s6;
	logic signed [15:0] ny_s6;
	logic signed [15:0] nz_s6;
	logic               v_s7;
	side_t              side_s7;
	logic signed [15:0] nx_s7;
	logic signed [15:0] ny_s7;
	logic signed [15:0] nz_s7;
	logic signed [32:0] qx_s7;
	logic signed [32:0] qy_s7;
	logic signed [32:0] qz_s7;
	side_t              side_s8;
	logic signed [15:0] nx_s8;
	logic signed [15:0] ny_s8;
	logic signed [15:0] nz_s8;
	logic signed [16:0] px_s8;
	logic signed [16:0] py_s8;
	logic signed [16:0] pz_s8;
	logic signed [16:0] rad_s;

	assign rad_s = $signed({1'b0, radius_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (adv) begin
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s5 <= side_s4;
			px_s5   <= 66'(cl_s4) * 66'(st_s4);
			pz_s5   <= 66'(sl_s4) * 66'(st_s4);
			ct_s5   <= ct_s4;
			side_s6 <= side_s5;
			nx_s6   <= norm_prod(px_s5);
			ny_s6   <= norm_cos(ct_s5);
			nz_s6   <= norm_prod(pz_s5);
			side_s7 <= side_s6;
			nx_s7   <= nx_s6;
			ny_s7   <= ny_s6;
			nz_s7   <= nz_s6;
			qx_s7   <= 33'(nx_s6) * 33'(rad_s);
			qy_s7   <= 33'(ny_s6) * 33'(rad_s);
			qz_s7   <= 33'(nz_s6) * 33'(rad_s);
			side_s8 <= side_s7;
			nx_s8   <= nx_s7;
			ny_s8   <= ny_s7;
			nz_s8   <= nz_s7;
			px_s8   <= pos_round(qx_s7);
			py_s8   <= pos_round(qy_s7);
			pz_s8   <= pos_round(qz_s7);
		end
	end

	assign out_ch.valid      = v_s8;
	assign out_ch.pos_x      = px_s8;
	assign out_ch.pos_y      = py_s8;
	assign out_ch.pos_z      = pz_s8;
	assign out_ch.norm_x     = nx_s8;
	assign out_ch.norm_y     = ny_s8;
	assign out_ch.norm_z     = nz_s8;
	assign out_ch.quad_valid = side_s8.qv;
	assign out_ch.corner_a   = side_s8.a;
	assign out_ch.corner_b   = side_s8.b;
	assign out_ch.corner_c   = side_s8.c;
	assign out_ch.corner_d   = side_s8.d;

	a_skid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q && !adv |=> skid_v_q)
		else $error("skid entry lost while stalled");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q && adv |=> v_s1)
		else $error("skid entry not moved into the pipeline");

	a_no_quad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.quad_valid |->
		out_ch.corner_a == '0 && out_ch.corner_b == '0 &&
		out_ch.corner_c == '0 && out_ch.corner_d == '0)
		else $error("corners set without a quad");

	a_quad_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.quad_valid |->
		out_ch.corner_c == out_ch.corner_b + KW'(1) &&
		out_ch.corner_d == out_ch.corner_a + KW'(1))
		else $error("quad corners inconsistent");

	a_norm_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |->
		out_ch.norm_x != 16'sh8000 && out_ch.norm_y != 16'sh8000 &&
		out_ch.norm_z != 16'sh8000)
		else $error("normal component out of range");

endmodule
`default_nettype wire

### sim/sphere_mesh_point_checker.sv
module sphere_mesh_point_checker (
	input  logic        clk,
	input  logic        arst_n,
	smpg_in_if          in_ch,
	smpg_out_if         out_ch,
	input  logic        cfg_we,
	input  logic [smpg_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [smpg_pkg::CFG_DATA_W-1:0] cfg_data,
	output int          pending,
	output int          errors
);

	typedef struct packed {
		logic signed [16:0] pos_x;
		logic signed [16:0] pos_y;
		logic signed [16:0] pos_z;
		logic signed [15:0] norm_x;
		logic signed [15:0] norm_y;
		logic signed [15:0] norm_z;
		logic               quad_valid;
		logic [smpg_pkg::CORNER_W-1:0] corner_a;
		logic [smpg_pkg::CORNER_W-1:0] corner_b;
		logic [smpg_pkg::CORNER_W-1:0] corner_c;
		logic [smpg_pkg::CORNER_W-1:0] corner_d;
	} vertex_t;

	logic [smpg_pkg::RAD_W-1:0] radius;
	logic [smpg_pkg::CNT_W-1:0] rings;
	logic [smpg_pkg::CNT_W-1:0] sects;
	vertex_t vertex_q[$];

	function automatic longint round_shift(longint v, int sh);
		longint mag;
		mag = v < 0 ? -v : v;
		mag = (mag + (longint'(1) << (sh - 1))) >>> sh;
		return v < 0 ? -mag : mag;
	endfunction

	function automatic longint sat_q15(longint v);
		if (v > 32767) return 32767;
		if (v < -32767) return -32767;
		return v;
	endfunction

	function automatic longint clamp_div(logic [smpg_pkg::CNT_W-1:0] n);
		if (n == 0) return 1;
		if (n > smpg_pkg::MAX_DIVISIONS_DEF) return smpg_pkg::MAX_DIVISIONS_DEF;
		return n;
	endfunction

	// sin and cos of a 32-bit turn angle at 2^30
	task automatic turn_trig(input logic [31:0] ang, output longint c, output longint s);
		longint x, y, z, dx, dy;
		x = smpg_pkg::CORDIC_X0;
		y = 0;
		z = longint'(ang[29:0]);
		for (int i = 0; i < smpg_pkg::CORDIC_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(smpg_pkg::ATAN_TURN[i]);
			end else begin
				x += dx; y -= dy; z += longint'(smpg_pkg::ATAN_TURN[i]);
			end
		end
		case (ang[31:30])
			2'd0: begin c = x;  s = y;  end
			2'd1: begin c = -y; s = x;  end
			2'd2: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase
	endtask

	task automatic sphere_vertex(input logic [smpg_pkg::CNT_W-1:0] r_in,
		input logic [smpg_pkg::CNT_W-1:0] s_in, output vertex_t v);
		longint rc, sc, ri, si, lon, lat, cl, sl, ct, st, nx, ny, nz, a, b;
		rc = clamp_div(rings);
		sc = clamp_div(sects);
		ri = r_in > rc ? rc : r_in;
		si = s_in > sc ? sc : s_in;
		lon = (((si << 16) + sc / 2) / sc) & 64'hFFFF;
		lat = ((ri << 15) + rc / 2) / rc;
		turn_trig(32'(lon << 16), cl, sl);
		turn_trig(32'(lat << 16), ct, st);
		nx = sat_q15(round_shift(cl * st, 45));
		ny = sat_q15(-round_shift(ct, 15));
		nz = sat_q15(round_shift(sl * st, 45));
		v.pos_x = 17'(round_shift(nx * longint'(radius), 15));
		v.pos_y = 17'(round_shift(ny * longint'(radius), 15));
		v.pos_z = 17'(round_shift(nz * longint'(radius), 15));
		v.norm_x = 16'(nx);
		v.norm_y = 16'(ny);
		v.norm_z = 16'(nz);
		if (ri < rc && si < sc) begin
			a = ri * (sc + 1) + si;
			b = (ri + 1) * (sc + 1) + si;
			v.quad_valid = 1'b1;
			v.corner_a = 20'(a);
			v.corner_b = 20'(b);
			v.corner_c = 20'(b + 1);
			v.corner_d = 20'(a + 1);
		end else begin
			v.quad_valid = 1'b0;
			v.corner_a = '0;
			v.corner_b = '0;
			v.corner_c = '0;
			v.corner_d = '0;
		end
	endtask

	assign pending = vertex_q.size();

	initial errors = 0;

	always @(posedge clk or negedge arst_n) begin
		vertex_t want, got;
		if (!arst_n) begin
			radius = smpg_pkg::RADIUS_RST;
			rings = smpg_pkg::COUNT_RST;
			sects = smpg_pkg::COUNT_RST;
			vertex_q.delete();
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				got = '{out_ch.pos_x, out_ch.pos_y, out_ch.pos_z, out_ch.norm_x,
					out_ch.norm_y, out_ch.norm_z, out_ch.quad_valid, out_ch.corner_a,
					out_ch.corner_b, out_ch.corner_c, out_ch.corner_d};
				if (vertex_q.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected transaction %p", got);
				end else begin
					want = vertex_q.pop_front();
					if (got !== want) begin
						errors++;
						if (errors <= 10) $display("mismatch\n  exp %p\n  got %p", want, got);
					end
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				sphere_vertex(in_ch.ring_index, in_ch.sector_index, want);
				vertex_q.insert(vertex_q.size(), want);
			end
			if (cfg_we) begin
				case (cfg_idx)
					smpg_pkg::REG_RADIUS: radius = cfg_data;
					smpg_pkg::REG_RINGS:  rings = cfg_data[smpg_pkg::CNT_W-1:0];
					smpg_pkg::REG_SECTS:  sects = cfg_data[smpg_pkg::CNT_W-1:0];
					default: ;
				endcase
			end
		end
	end
endmodule

### sim/sphere_mesh_point_generator_tb.sv
module sphere_mesh_point_generator_tb;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [smpg_pkg::CFG_IDX_W-1:0] cfg_idx;
	logic [smpg_pkg::CFG_DATA_W-1:0] cfg_data;
	int pending;
	int errors;
	bit steady;
	bit hold_req;
	int cur_rings;
	int cur_sects;

	smpg_in_if in_ch();
	smpg_out_if out_ch();

	sphere_mesh_point_generator u_top (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	sphere_mesh_point_checker u_chk (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.pending(pending), .errors(errors)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("sphere_mesh_point_generator_tb: done, errors");
		$finish;
	end

	// output side: random stalls plus one long hold-off on request
	initial begin
		int hold;
		out_ch.ready = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 0;
				hold = 300;
			end
			if (hold > 0) begin
				out_ch.ready = 0;
				hold--;
			end else begin
				out_ch.ready = steady || $urandom_range(99) >= 38;
			end
		end
	end

	task automatic send_point(input int r, input int s);
		if (!steady) begin
			while ($urandom_range(99) < 38) begin
				in_ch.valid = 0;
				@(negedge clk);
			end
		end
		in_ch.valid = 1;
		in_ch.ring_index = r[smpg_pkg::CNT_W-1:0];
		in_ch.sector_index = s[smpg_pkg::CNT_W-1:0];
		do @(posedge clk); while (!in_ch.ready);
		@(negedge clk);
		in_ch.valid = 0;
	endtask

	task automatic write_reg(input logic [smpg_pkg::CFG_IDX_W-1:0] idx, input int val);
		cfg_we = 1;
		cfg_idx = idx;
		cfg_data = val[smpg_pkg::CFG_DATA_W-1:0];
		@(negedge clk);
		cfg_we = 0;
	endtask

	task automatic drain;
		while (pending != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic set_sphere(input int rad, input int r, input int s);
		drain();
		write_reg(smpg_pkg::REG_RADIUS, rad);
		write_reg(smpg_pkg::REG_RINGS, r);
		write_reg(smpg_pkg::REG_SECTS, s);
		cur_rings = r == 0 ? 1 : r;
		cur_sects = s == 0 ? 1 : s;
	endtask

	task automatic random_points(input int n);
		int r, s;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(9) < 8) begin
				r = $urandom_range(cur_rings);
				s = $urandom_range(cur_sects);
			end else begin
				r = $urandom_range(1023);
				s = $urandom_range(1023);
			end
			send_point(r, s);
		end
	endtask

	initial begin
		arst_n = 0;
		cfg_we = 0;
		cfg_idx = '0;
		cfg_data = '0;
		in_ch.valid = 0;
		in_ch.ring_index = '0;
		in_ch.sector_index = '0;
		steady = 0;
		hold_req = 0;
		cur_rings = 100;
		cur_sects = 100;
		repeat (3) @(negedge clk);
		arst_n = 1;

		send_point(0, 0);
		send_point(1023, 1023);
		send_point(100, 100);
		send_point(99, 99);
		send_point(50, 25);
		send_point(50, 75);
		send_point(0, 100);
		send_point(100, 0);
		send_point(512, 1);

		set_sphere(65535, 1023, 1023);
		send_point(1022, 1022);
		send_point(1023, 0);
		send_point(0, 1023);
		send_point(511, 255);
		send_point(682, 341);

		set_sphere(0, 0, 0);
		send_point(0, 0);
		send_point(1, 1);
		send_point(1023, 0);

		set_sphere(256, 1, 4);
		send_point(0, 3);
		send_point(1, 2);
		send_point(0, 4);

		set_sphere(32768, 4, 1);
		send_point(2, 0);
		send_point(3, 1);
		random_points(100);

		set_sphere($urandom_range(65535), $urandom_range(1, 1023), $urandom_range(1, 1023));
		hold_req = 1;
		random_points(250);

		set_sphere(154, 100, 100);
		steady = 1;
		random_points(200);
		steady = 0;

		set_sphere($urandom_range(65535), $urandom_range(1, 20), $urandom_range(1, 20));
		random_points(200);

		set_sphere(65535, $urandom_range(1, 1023), $urandom_range(1, 1023));
		random_points(175);

		drain();
		if (errors == 0) begin
			$display("sphere_mesh_point_generator_tb: done, clean");
		end else begin
			$display("sphere_mesh_point_generator_tb: done, errors");
		end
		$finish;
	end
endmodule

### sim.f
rtl/smpg_pkg.sv
rtl/smpg_in_if.sv
rtl/smpg_out_if.sv
rtl/sphere_mesh_point_generator.sv
sim/sphere_mesh_point_checker.sv
sim/sphere_mesh_point_generator_tb.sv
